### sv/indexed_list_with_shift_delete_top_macros.svh
// Assertion macros shared by the indexed list RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef INDEXED_LIST_WITH_SHIFT_DELETE_TOP_MACROS_SVH
`define INDEXED_LIST_WITH_SHIFT_DELETE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ILSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("ilsd assertion failed");
`define ILSD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ilsd assertion failed");
`else
`define ILSD_ASSERT(lbl, clk, rstn, prop)
`define ILSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### sv/ilsd_pkg.sv
// Package for the indexed list: sizes, operation and status codes, cell control type.
// Depends on nothing; used by ilsd_if, ilsd_cell and the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package ilsd_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 4;
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_SET    = 2'd1,
		OP_GET    = 2'd2,
		OP_DELETE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### sv/ilsd_if.sv
// Request and response channel interfaces of the indexed list.
// Depends on ilsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ilsd_req_if import ilsd_pkg::*; ();
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [POS_W-1:0]    position;
	logic [WORD_W-1:0]   word_in;

	modport source (output valid, output opcode, output position, output word_in,
		input ready);
	modport sink (input valid, input opcode, input position, input word_in,
		output ready);
endinterface

interface ilsd_rsp_if import ilsd_pkg::*; ();
	logic                valid;
	logic                ready;
	status_t             status;
	logic [WORD_W-1:0]   read_word;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output status, output read_word, output count,
		input ready);
	modport sink (input valid, input status, input read_word, input count,
		output ready);
endinterface

`default_nettype wire

### sv/ilsd_cell.sv
// One storage cell of the list: holds a word, loads a new one or takes its upper neighbor's.
// Depends on ilsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilsd_cell import ilsd_pkg::*; (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [DATA_WIDTH-1:0] wr_word,
	input  wire logic [DATA_WIDTH-1:0] shift_in,
	output logic      [DATA_WIDTH-1:0] word
);

	logic [DATA_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= wr_word;
		end else if (ctrl.shift) begin
			word_q <= shift_in;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

### sv/indexed_list_with_shift_delete_top.sv
// Top level of the indexed list: control, element count, row of cells and response register.
// Depends on ilsd_pkg, ilsd_if, ilsd_cell and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_list_with_shift_delete_top_macros.svh"

// Packed list of up to CAPACITY words held in a row of cells. Each request transaction
// (append, set, get or delete) is executed in the cycle it is accepted and its response
// transaction is valid in the next cycle, so one request is taken every cycle while the
// response side keeps up. A delete moves every later cell down by one place in that same
// cycle, each cell taking its upper neighbor's word. The request side stalls only while a
// response waits in the output register and is not being taken.
module indexed_list_with_shift_delete_top import ilsd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ilsd_req_if.sink   req,
	ilsd_rsp_if.source rsp
);

	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [WORD_W-1:0]     read_word_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic                  accept;
	logic [CNT_W-1:0]      pos_ext;
	logic                  full;
	logic                  in_range;
	logic                  do_write;
	logic                  do_delete;
	logic [CNT_W-1:0]      wr_idx;
	logic [CNT_W-1:0]      count_d;
	status_t               status_d;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [DATA_WIDTH-1:0] wr_word;
	cell_ctrl_t            ctrl [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_word [CAPACITY];

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos_ext   = CNT_W'(req.position);
	assign full      = (count_q >= CNT_W'(CAPACITY));
	assign in_range  = (pos_ext < count_q);
	assign wr_word   = DATA_WIDTH'(req.word_in);

	always_comb begin
		do_write  = 1'b0;
		do_delete = 1'b0;
		wr_idx    = pos_ext;
		count_d   = count_q;
		status_d  = ST_OK;
		unique case (req.opcode)
			OP_APPEND: begin
				wr_idx = count_q;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					do_write = accept;
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_SET: begin
				if (in_range) begin
					do_write = accept;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_GET: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end
			end
			OP_DELETE: begin
				if (in_range) begin
					do_delete = accept;
					count_d   = count_q - CNT_W'(1);
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CNT_W'(i) == pos_ext) begin
				rd_word = rd_word | cell_word[i];
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] shift_in;

		assign ctrl[i].load  = do_write && (wr_idx == CNT_W'(i));
		assign ctrl[i].shift = do_delete && (CNT_W'(i) >= pos_ext);

		if (i == CAPACITY - 1) begin : g_last
			assign shift_in = cell_word[i];
		end else begin : g_mid
			assign shift_in = cell_word[i + 1];
		end

		ilsd_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl[i]),
			.wr_word  (wr_word),
			.shift_in (shift_in),
			.word     (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			out_count_q <= COUNT_W'(count_d);
			if (req.opcode == OP_GET && in_range) begin
				read_word_q <= WORD_W'(rd_word);
			end else begin
				read_word_q <= '0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.read_word = read_word_q;
	assign rsp.count     = out_count_q;

	`ILSD_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`ILSD_ASSERT(a_append_grows, clk, arst_n, (accept && req.opcode == OP_APPEND && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
	`ILSD_ASSERT(a_idle_count, clk, arst_n, !accept |=> $stable(count_q))
	`ILSD_ASSERT(a_accept_rsp, clk, arst_n, accept |=> (out_valid_q && out_count_q == COUNT_W'(count_q)))
	`ILSD_ASSERT_ALWAYS(a_single_load, clk, !(do_write && do_delete))

endmodule

`default_nettype wire
